@@ design/bmhq_pkg.sv @@
// Shared constants, codes and types for the binary max-heap queue.
package bmhq_pkg;

   localparam int CAPACITY = 1024;
   localparam int KEY_W    = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int SLOT_W   = COUNT_W;
   localparam int CHILD_W  = SLOT_W + 1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_READ,
      S_UP_CMP,
      S_RM_LOAD,
      S_DN_READ,
      S_DN_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type               status;
      logic signed [KEY_W-1:0]  removed_value;
      logic [COUNT_W-1:0]       element_count;
   } result_type;

endpackage

@@ design/bmhq_if.sv @@
// Request and response channel interfaces of the heap queue.
interface bmhq_req_if;
   import bmhq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic signed [KEY_W-1:0] insert_value;
   modport source (output valid, operation, insert_value, input ready);
   modport sink   (input valid, operation, insert_value, output ready);
endinterface

interface bmhq_rsp_if;
   import bmhq_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic signed [KEY_W-1:0] removed_value;
   logic [COUNT_W-1:0]      element_count;
   modport source (output valid, status, removed_value, element_count, input ready);
   modport sink   (input valid, status, removed_value, element_count, output ready);
endinterface

@@ design/binary_max_heap_queue_top.sv @@
// Binary max-heap priority queue, 1024 signed 32-bit keys in a registered-read RAM.
// One item at a time, from accept to result handoff through the response register:
// an insert sifts up toward the root, at most 10 levels; a remove-max sifts down toward
// a leaf. An insert when full or a remove when empty goes straight to the result.
// A stalled result holds off the next input.
// Synchronous active-high reset empties the queue; RAM contents are not cleared.
module binary_max_heap_queue_top (
   input  logic        clock,
   input  logic        reset,
   bmhq_req_if.sink    req_chan,
   bmhq_rsp_if.source  rsp_chan
);
   import bmhq_pkg::*;

   logic              res_valid, res_ready;
   result_type        res;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [KEY_W-1:0]  wr_data, rd_data_a, rd_data_b;

   bmhq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   bmhq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   bmhq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ design/bmhq_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
module bmhq_ram #(
   parameter  int DEPTH = 1024,
   parameter  int WIDTH = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

@@ design/bmhq_seq.sv @@
// Sequencer: insert with sift-up, remove-max with sift-down, over the heap RAM.
module bmhq_seq (
   input  logic                           clock,
   input  logic                           reset,
   bmhq_req_if.sink                       req_chan,
   output logic                           res_valid,
   input  logic                           res_ready,
   output bmhq_pkg::result_type           res,
   output logic                           wr_en,
   output logic [bmhq_pkg::ADDR_W-1:0]    wr_addr,
   output logic [bmhq_pkg::KEY_W-1:0]     wr_data,
   output logic [bmhq_pkg::ADDR_W-1:0]    rd_addr_a,
   output logic [bmhq_pkg::ADDR_W-1:0]    rd_addr_b,
   input  logic [bmhq_pkg::KEY_W-1:0]     rd_data_a,
   input  logic [bmhq_pkg::KEY_W-1:0]     rd_data_b
);
   import bmhq_pkg::*;

   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [SLOT_W-1:0]       pos_ff, pos_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] removed_ff, removed_in;
   status_type              status_ff, status_in;

   logic signed [KEY_W-1:0] data_a, data_b, big;
   logic [CHILD_W-1:0]      child, n_ext;
   logic                    take_right;
   logic [SLOT_W-1:0]       parent;

   assign data_a = rd_data_a;
   assign data_b = rd_data_b;
   assign child  = {pos_ff, 1'b0};
   assign n_ext  = {1'b0, count_ff};
   assign parent = pos_ff >> 1;
   // ties go to the left child
   assign take_right = (child < n_ext) && (data_a < data_b);
   assign big        = take_right ? data_b : data_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      key_ff     <= key_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      key_in     = key_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = ADDR_W'(pos_ff - 1'b1);
      wr_data    = key_ff;
      rd_addr_a  = '0;
      rd_addr_b  = '0;
      req_chan.ready = 1'b0;
      res_valid  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            // root and last slot are fetched at accept for a remove
            rd_addr_a = '0;
            rd_addr_b = ADDR_W'(count_ff - 1'b1);
            if (req_chan.valid) begin
               removed_in = '0;
               status_in  = STATUS_DONE;
               if (req_chan.operation == OP_INSERT) begin
                  if (count_ff == COUNT_W'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     count_in = count_ff + 1'b1;
                     pos_in   = SLOT_W'(count_ff + 1'b1);
                     key_in   = req_chan.insert_value;
                     state_in = S_UP_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     count_in = count_ff - 1'b1;
                     state_in = S_RM_LOAD;
                  end
               end
            end
         end

         S_UP_READ: begin
            if (pos_ff == SLOT_W'(1)) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr_a = ADDR_W'(parent - 1'b1);
               state_in  = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            wr_en = 1'b1;
            if (data_a < key_ff) begin
               wr_data  = data_a;
               pos_in   = parent;
               state_in = S_UP_READ;
            end else begin
               state_in = S_DONE;
            end
         end

         S_RM_LOAD: begin
            removed_in = data_a;
            key_in     = data_b;
            pos_in     = SLOT_W'(1);
            state_in   = S_DN_READ;
         end

         S_DN_READ: begin
            if (child <= n_ext) begin
               rd_addr_a = ADDR_W'(child - 1'b1);
               rd_addr_b = ADDR_W'(child);
               state_in  = S_DN_CMP;
            end else begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end
         end

         S_DN_CMP: begin
            wr_en = 1'b1;
            if (key_ff >= big) begin
               state_in = S_DONE;
            end else begin
               wr_data  = big;
               pos_in   = SLOT_W'(child + CHILD_W'(take_right));
               state_in = S_DN_READ;
            end
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res.status        = status_ff;
   assign res.removed_value = removed_ff;
   assign res.element_count = count_ff;

endmodule

@@ design/bmhq_out.sv @@
// Response output register between the sequencer and the response channel.
module bmhq_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   output logic                 res_ready,
   input  bmhq_pkg::result_type res,
   bmhq_rsp_if.source           rsp_chan
);
   import bmhq_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign res_ready = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         valid_in = 1'b1;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.status        = data_ff.status;
   assign rsp_chan.removed_value = data_ff.removed_value;
   assign rsp_chan.element_count = data_ff.element_count;

endmodule

@@ design/bmhq_check.sv @@
// Port-level checks for the heap queue, bound to the top level.
module bmhq_check (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_status,
   input logic [bmhq_pkg::KEY_W-1:0]   rsp_removed_value,
   input logic [bmhq_pkg::COUNT_W-1:0] rsp_element_count
);
   import bmhq_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_removed_value) && $stable(rsp_element_count))
      else $error("stalled response changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_element_count <= COUNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |->
         rsp_element_count == '0 && rsp_removed_value == '0)
      else $error("empty status with keys held or nonzero value");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_element_count == COUNT_W'(CAPACITY) && rsp_removed_value == '0)
      else $error("full status without full heap");

endmodule

bind binary_max_heap_queue_top bmhq_check u_check (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_removed_value (rsp_chan.removed_value),
   .rsp_element_count (rsp_chan.element_count)
);
